[rtl/core/mis_pkg.sv]
package mis_pkg;

  // Width of the operand and inverse fields on the ports.
  localparam int FIELD_W = 16;
  // Candidate counter width; the search limit must not exceed 16 bits, which the block does not enforce.
  localparam int CAND_W  = 16;
  localparam int UPC_W   = 4;

  typedef logic [1:0]       status_t;
  typedef logic [UPC_W-1:0] upc_t;

  localparam status_t ST_FOUND     = 2'd0;
  localparam status_t ST_MULTIPLE  = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_ZERO      = 2'd3;

  // Microprogram step addresses.
  localparam upc_t A_IDLE  = 4'd0;
  localparam upc_t A_ZCHK  = 4'd1;
  localparam upc_t A_DIVA  = 4'd2;
  localparam upc_t A_WAITA = 4'd3;
  localparam upc_t A_MCHK  = 4'd4;
  localparam upc_t A_MULT  = 4'd5;
  localparam upc_t A_DIVB  = 4'd6;
  localparam upc_t A_WAITB = 4'd7;
  localparam upc_t A_INIT  = 4'd8;
  localparam upc_t A_LOOP  = 4'd9;
  localparam upc_t A_LCHK  = 4'd10;
  localparam upc_t A_FOUND = 4'd11;
  localparam upc_t A_NF    = 4'd12;
  localparam upc_t A_ZERO  = 4'd13;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_MV,
    OP_DIV_VM,
    OP_INIT,
    OP_STEP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CD_ALWAYS,
    CD_START,
    CD_ZERO,
    CD_DIV_BUSY,
    CD_REM_NZ,
    CD_EXIT,
    CD_LIMIT
  } cond_t;

  typedef struct packed {
    op_t     op;
    cond_t   cond;
    logic    inv;
    upc_t    target;
    status_t status;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic zero;
    logic div_busy;
    logic rem_nz;
    logic search_exit;
    logic at_limit;
  } flags_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] modulus;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] inverse;
    status_t            status;
  } res_t;

endpackage

[rtl/core/mis_rem.sv]
module mis_rem import mis_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    partial;
  logic [W+1:0]  diff;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    partial = {rem_r, dvd_r[W-1]};
    diff    = {1'b0, partial} - {2'b00, dvs_r};
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      rem_nxt = diff[W+1] ? partial[W-1:0] : diff[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = (cnt_r != '0);
  assign rem  = rem_r;

endmodule

[rtl/core/mis_seq.sv]
module mis_seq import mis_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl,
  output logic   busy
);

  upc_t upc_r, upc_nxt;
  logic cond_hit;
  logic take;

  // Microprogram: one control word per step.
  always_comb begin
    unique case (upc_r)
      A_IDLE:  ctrl = '{OP_LOAD,   CD_START,    1'b1, A_IDLE,  ST_FOUND};
      A_ZCHK:  ctrl = '{OP_NOP,    CD_ZERO,     1'b0, A_ZERO,  ST_FOUND};
      A_DIVA:  ctrl = '{OP_DIV_MV, CD_ALWAYS,   1'b1, A_IDLE,  ST_FOUND};
      A_WAITA: ctrl = '{OP_NOP,    CD_DIV_BUSY, 1'b0, A_WAITA, ST_FOUND};
      A_MCHK:  ctrl = '{OP_NOP,    CD_REM_NZ,   1'b0, A_DIVB,  ST_FOUND};
      A_MULT:  ctrl = '{OP_EMIT,   CD_ALWAYS,   1'b0, A_IDLE,  ST_MULTIPLE};
      A_DIVB:  ctrl = '{OP_DIV_VM, CD_ALWAYS,   1'b1, A_IDLE,  ST_FOUND};
      A_WAITB: ctrl = '{OP_NOP,    CD_DIV_BUSY, 1'b0, A_WAITB, ST_FOUND};
      A_INIT:  ctrl = '{OP_INIT,   CD_ALWAYS,   1'b1, A_IDLE,  ST_FOUND};
      A_LOOP:  ctrl = '{OP_STEP,   CD_EXIT,     1'b1, A_LOOP,  ST_FOUND};
      A_LCHK:  ctrl = '{OP_NOP,    CD_LIMIT,    1'b0, A_NF,    ST_FOUND};
      A_FOUND: ctrl = '{OP_EMIT,   CD_ALWAYS,   1'b0, A_IDLE,  ST_FOUND};
      A_NF:    ctrl = '{OP_EMIT,   CD_ALWAYS,   1'b0, A_IDLE,  ST_NOT_FOUND};
      A_ZERO:  ctrl = '{OP_EMIT,   CD_ALWAYS,   1'b0, A_IDLE,  ST_ZERO};
      default: ctrl = '{OP_NOP,    CD_ALWAYS,   1'b0, A_IDLE,  ST_FOUND};
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      CD_ALWAYS:   cond_hit = 1'b1;
      CD_START:    cond_hit = flags.start;
      CD_ZERO:     cond_hit = flags.zero;
      CD_DIV_BUSY: cond_hit = flags.div_busy;
      CD_REM_NZ:   cond_hit = flags.rem_nz;
      CD_EXIT:     cond_hit = flags.search_exit;
      CD_LIMIT:    cond_hit = flags.at_limit;
      default:     cond_hit = 1'b0;
    endcase
    take    = cond_hit ^ ctrl.inv;
    upc_nxt = take ? ctrl.target : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= A_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign busy = (upc_r != A_IDLE);

endmodule

[rtl/core/modular_inverse_search.sv]
// Brute-force modular inverse engine.
// A request (value, modulus) is taken at a rising edge where start is high
// and busy is low. Operands are cut to OPERAND_WIDTH bits. Exactly one result
// (inverse, status) follows, shown on out_res for one cycle with out_valid
// high; the receiver must take it then, as it cannot hold results off.
// A zero operand ends the request with status zero-operand. Next the
// modulus is reduced by the value in a restoring remainder unit that takes
// one bit per cycle; a zero remainder ends the request with status multiple.
// Otherwise the value is reduced by the modulus in the same unit and the
// search walks the candidates one per cycle.
// One request is handled at a time; busy stays high until its result shows.
// Synchronous reset returns the sequencer to its idle step, clears the result
// strobe and the remainder counter; nothing else needs clearing.
module modular_inverse_search import mis_pkg::*; #(
  parameter int SEARCH_LIMIT  = 65535,
  parameter int OPERAND_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output res_t out_res
);

  // Inputs are only FIELD_W bits wide, so wider settings behave as FIELD_W.
  localparam int DW = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;

  ctrl_t  ctrl;
  flags_t flags;

  logic [DW-1:0]     v_r, v_nxt;
  logic [DW-1:0]     m_r, m_nxt;
  logic [DW-1:0]     step_r, step_nxt;
  logic [DW-1:0]     acc_r, acc_nxt;
  logic [CAND_W-1:0] cand_r, cand_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  logic              accept;
  logic              rem_start;
  logic [DW-1:0]     rem_dividend;
  logic [DW-1:0]     rem_divisor;
  logic              rem_busy;
  logic [DW-1:0]     rem_val;
  logic [DW:0]       acc_sum;
  logic              at_limit;
  logic              acc_one;

  mis_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // The same remainder unit serves both reductions: modulus by value first,
  // then value by modulus to give the search increment.
  assign rem_start    = (ctrl.op == OP_DIV_MV) || (ctrl.op == OP_DIV_VM);
  assign rem_dividend = (ctrl.op == OP_DIV_MV) ? m_r : v_r;
  assign rem_divisor  = (ctrl.op == OP_DIV_MV) ? v_r : m_r;

  mis_rem #(.W(DW)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .busy     (rem_busy),
    .rem      (rem_val)
  );

  assign accept   = start && !busy;
  assign at_limit = (cand_r >= CAND_W'(SEARCH_LIMIT));
  assign acc_one  = (acc_r == DW'(1));

  always_comb begin
    flags.start       = start;
    flags.zero        = (v_r == '0) || (m_r == '0);
    flags.div_busy    = rem_busy;
    flags.rem_nz      = (rem_val != '0);
    flags.search_exit = at_limit || acc_one;
    flags.at_limit    = at_limit;
  end

  // Datapath: the accumulator holds value * candidate mod modulus, and gains
  // the reduced value once per candidate. Both terms stay below the modulus,
  // so a single conditional subtraction brings the sum back into range.
  always_comb begin
    v_nxt       = v_r;
    m_nxt       = m_r;
    step_nxt    = step_r;
    acc_nxt     = acc_r;
    cand_nxt    = cand_r;
    acc_sum     = {1'b0, acc_r} + {1'b0, step_r};
    out_res_nxt = out_res_r;
    unique case (ctrl.op)
      OP_LOAD: begin
        if (accept) begin
          v_nxt = in_req.value[DW-1:0];
          m_nxt = in_req.modulus[DW-1:0];
        end
      end
      OP_INIT: begin
        step_nxt = rem_val;
        acc_nxt  = '0;
        cand_nxt = '0;
      end
      OP_STEP: begin
        if (!(at_limit || acc_one)) begin
          acc_nxt  = (acc_sum >= {1'b0, m_r}) ? DW'(acc_sum - {1'b0, m_r})
                                              : acc_sum[DW-1:0];
          cand_nxt = cand_r + 1'b1;
        end
      end
      OP_EMIT: begin
        out_res_nxt.status  = ctrl.status;
        out_res_nxt.inverse = (ctrl.status == ST_FOUND) ?
                              FIELD_W'(cand_r[DW-1:0]) : '0;
      end
      default: begin
      end
    endcase
    out_valid_nxt = (ctrl.op == OP_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    m_r       <= m_nxt;
    step_r    <= step_nxt;
    acc_r     <= acc_nxt;
    cand_r    <= cand_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // The result strobe only appears once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while sequencer still busy");

  // A taken request always occupies the engine in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request accepted but engine not busy");

  // Candidate zero never succeeds, as the accumulator starts at zero.
  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status == ST_FOUND)) |-> (out_res.inverse != '0))
    else $error("found status with zero inverse");

  // Every other outcome carries a zero inverse.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status != ST_FOUND)) |-> (out_res.inverse == '0))
    else $error("failed search carries non-zero inverse");

endmodule

[tb/tb.sv]
module tb;
  import mis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built at its default size, and the predictor follows it.
  localparam int unsigned SEARCH_LIMIT  = 65535;
  localparam int unsigned OPERAND_WIDTH = 16;

  // Stimulus sizing. A search that runs out of candidates is long, so only a
  // handful of such requests are allowed into the random part. Everything
  // costing more than SLOW_COST candidates counts as slow.
  localparam int RANDOM_ITEMS = 100;
  localparam int CALM_ITEMS   = 20;
  localparam int unsigned SLOW_COST = 1000;
  // After the last result, allow time for any stray strobe to show up.
  localparam int SETTLE_CYCLES = 100;
  // The limit lies well above the slowest legal run of the stimulus below.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // Holds the predicted result of every request accepted and still awaiting
  // its answer, and checks each answer as it appears.
  class InverseScoreboard;
    res_t pending_results[$];
    int   mismatches = 0;

    // Brute-force search: candidates from zero upward, keeping the running
    // product value * candidate mod modulus as an accumulator.
    function res_t find_inverse(req_t r);
      res_t        res;
      int unsigned v;
      int unsigned m;
      int unsigned step;
      int unsigned acc;
      v = r.value;
      m = r.modulus;
      res.inverse = '0;
      res.status  = ST_NOT_FOUND;
      if (v == 0 || m == 0) begin
        res.status = ST_ZERO;
      end else if (m % v == 0) begin
        res.status = ST_MULTIPLE;
      end else begin
        step = v % m;
        acc  = 0;
        for (int unsigned cand = 0; cand < SEARCH_LIMIT; cand++) begin
          if (acc == 1) begin
            res.inverse = FIELD_W'(cand);
            res.status  = ST_FOUND;
            break;
          end
          acc += step;
          if (acc >= m) acc -= m;
        end
      end
      return res;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    function void note_request(req_t r);
      pending_results.push_back(find_inverse(r));
    endfunction

    task check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result inverse=%0d status=%0d with no request outstanding",
                         got.inverse, got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.inverse !== want.inverse)
          report($sformatf("inverse %0d, predicted %0d", got.inverse, want.inverse));
        if (got.status !== want.status)
          report($sformatf("status %0d, predicted %0d", got.status, want.status));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  res_t out_res;

  InverseScoreboard sb = new();
  int unsigned cycle_count = 0;
  int          slow_left = 4;

  modular_inverse_search #(
    .SEARCH_LIMIT (SEARCH_LIMIT),
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // A runaway search or a lost strobe would otherwise hang the run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Observation of both channels. Everything here is read in the active
  // region of the edge, so it sees the values from before the edge, exactly
  // as the block does. A result is checked before a request taken at the
  // same edge is noted, which keeps the order of the queue plain to follow.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_res);
      if (start && !busy) sb.note_request(in_req);
    end
  end

  // Presents one request and returns at the edge where it is taken. Start is
  // left high, so a following request can go out back to back without the
  // strobe being lowered and raised in the same time step.
  task automatic send_request(input req_t r);
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Sender idles for a while; the request lines carry noise meanwhile, which
  // the block must ignore since start is low.
  task automatic pause_sender(input int cycles);
    start  <= 1'b0;
    in_req <= req_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Holds off until every accepted request has been answered. The first edge
  // lets the observer note a request taken at the edge just gone.
  task automatic wait_for_answers();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Draws one random request. Most use a small modulus, so the search ends
  // quickly unless the value shares a factor with it; some are built so a
  // wide modulus still has a small inverse. Requests that would search for
  // long are only let through while the slow allowance lasts.
  task automatic make_random_request(output req_t r);
    res_t        probe;
    int unsigned kind;
    int unsigned cost;
    int unsigned k;
    bit          taken;
    taken = 1'b0;
    while (!taken) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          // A zero operand on one side or both.
          r.value   = ($urandom_range(0, 1) != 0) ? '0 : FIELD_W'($urandom);
          r.modulus = (r.value != 0) ? '0 : FIELD_W'($urandom);
        end
        1: begin
          // The modulus is an exact multiple of the value.
          r.value   = FIELD_W'($urandom_range(1, 300));
          r.modulus = FIELD_W'(r.value * $urandom_range(1, 65535 / r.value));
        end
        2: begin
          // Wide modulus: take the inverse of a small number as the value,
          // lifted by a random multiple of the modulus to reach the top bits.
          r.modulus = FIELD_W'($urandom_range(256, 65535));
          r.value   = FIELD_W'($urandom_range(2, 200));
          probe     = sb.find_inverse(r);
          if (probe.status == ST_FOUND) begin
            k       = $urandom_range(0, (65535 - probe.inverse) / r.modulus);
            r.value = FIELD_W'(probe.inverse + k * r.modulus);
          end
        end
        3: r = req_t'($urandom);
        default: begin
          r.value   = FIELD_W'($urandom);
          r.modulus = FIELD_W'($urandom_range(2, 255));
        end
      endcase
      probe = sb.find_inverse(r);
      if (probe.status == ST_NOT_FOUND) cost = SEARCH_LIMIT;
      else if (probe.status == ST_FOUND) cost = probe.inverse;
      else cost = 0;
      if (cost <= SLOW_COST) begin
        taken = 1'b1;
      end else if (slow_left > 0) begin
        slow_left--;
        taken = 1'b1;
      end
    end
  endtask

  initial begin
    req_t directed[] = '{
      '{16'd0,     16'd0},      // both operands zero
      '{16'd0,     16'd65535},  // zero value
      '{16'd65535, 16'd0},      // zero modulus
      '{16'd1,     16'd65535},  // value one divides every modulus
      '{16'd1,     16'd1},
      '{16'd65535, 16'd65535},  // modulus equal to value
      '{16'd3,     16'd65535},  // modulus a wider multiple of value
      '{16'd255,   16'd65535},
      '{16'd3,     16'd7},      // ordinary search
      '{16'd10,    16'd3},      // value above modulus
      '{16'd4,     16'd3},
      '{16'd5,     16'd3},
      '{16'd65535, 16'd2},      // all-ones value against the smallest modulus above one
      '{16'd32768, 16'd65535},  // top bit alone; inverse is two
      '{16'd21845, 16'd43691},  // alternating bit patterns
      '{16'd2,     16'd65535},  // inverse sits half way up the range
      '{16'd65534, 16'd65535},  // inverse at the very top of the range
      '{16'd2,     16'd1},      // modulus one: the search runs out
      '{16'd6,     16'd9}       // shared factor: the search runs out
    };
    req_t r;

    rst_n  = 1'b0;
    start  = 1'b0;
    in_req = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests, with the odd idle burst between them.
    foreach (directed[i]) begin
      send_request(directed[i]);
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 9));
    end

    // Let the block go completely quiet once before the random part.
    wait_for_answers();

    // Random requests. Idle bursts are frequent early on and absent over the
    // final stretch, where requests go out back to back; part way through the
    // sender again waits for every answer.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      make_random_request(r);
      send_request(r);
      if (i == RANDOM_ITEMS / 2) begin
        wait_for_answers();
      end else if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 2) == 0) begin
        pause_sender($urandom_range(1, 9));
      end
    end

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
